// ===== rtl/core/psrf_pkg.sv =====
`default_nettype none

package psrf_pkg;

    // Longest run tracked, in characters or pairs
    localparam int RUN_CAP     = 1023;
    localparam int LEN_W       = $clog2(RUN_CAP + 1);
    localparam int MIN_CHARS   = 4;
    localparam int MAX_CHARS   = 500;
    localparam int LIMIT_W     = 20;
    localparam int LIMIT_RESET = 500000;
    localparam int OFFSET_W    = 32;
    localparam int COUNT_W     = 9;

    // Result queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef logic [LEN_W-1:0]    len_t;
    typedef logic [LEN_W+2:0]    ratio_t;
    typedef logic [OFFSET_W-1:0] offset_t;
    typedef logic [LIMIT_W-1:0]  limit_t;

    typedef enum logic
    {
        RUN_ASCII = 1'b0,
        RUN_WIDE  = 1'b1
    } run_kind_t;

    typedef struct packed
    {
        run_kind_t            kind;
        offset_t              start;
        logic [COUNT_W-1:0]   count;
        logic                 eob;
    } result_t;

    // Printable ASCII: space up to tilde
    function automatic logic is_printable(input logic [7:0] b);
        return (b >= 8'd32) && (b < 8'd127);
    endfunction

    // Letters, digits and . _ - / : @ #
    function automatic logic is_good(input logic [7:0] b);
        logic alpha_up;
        logic alpha_lo;
        logic digit;
        logic punct;
        alpha_up = (b >= 8'h41) && (b <= 8'h5A);
        alpha_lo = (b >= 8'h61) && (b <= 8'h7A);
        digit    = (b >= 8'h30) && (b <= 8'h39);
        punct    = (b == 8'h2E) || (b == 8'h5F) || (b == 8'h2D) || (b == 8'h2F) ||
                   (b == 8'h3A) || (b == 8'h40) || (b == 8'h23);
        return alpha_up || alpha_lo || digit || punct;
    endfunction

    // Length window and good*5 > len*4
    function automatic logic run_qualifies(input len_t len, input len_t good);
        ratio_t g5;
        ratio_t l4;
        g5 = ratio_t'(good) * ratio_t'(5);
        l4 = ratio_t'(len) * ratio_t'(4);
        return (len >= len_t'(MIN_CHARS)) && (len <= len_t'(MAX_CHARS)) && (g5 > l4);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/printable_string_run_finder.sv =====
`default_nettype none

// Channel   Dir  Handshake            Payload
// in        in   in_valid/in_stall    byte_value, last_byte
// out       out  out_valid/out_stall  run_kind, start_offset, char_count, end_of_burst
// cfg       in   cfg_valid/cfg_ready  cfg_data (found_limit)
//
// One byte is taken per cycle; the run counters update in the accept cycle and
// each byte pushes zero, one or two items into a four-entry result queue.
// Results drain one per cycle; in_stall rises while fewer than two queue slots
// are free, so sustained rate is one byte per cycle unless results back up.
// rst_n clears all but queue storage asynchronously; found_limit resets to 500000.
// cfg_ready is always high; a write takes effect at the next edge.
module printable_string_run_finder
    import psrf_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [7:0]           byte_value,
    input  wire logic                 last_byte,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      run_kind,
    output logic [OFFSET_W-1:0]       start_offset,
    output logic [COUNT_W-1:0]        char_count,
    output logic                      end_of_burst,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [LIMIT_W-1:0]   cfg_data
);

    // Scan state
    limit_t   limit_reg;
    offset_t  pos_reg,        pos_next;
    logic     a_active_reg,   a_active_next;
    offset_t  a_start_reg,    a_start_next;
    len_t     a_len_reg,      a_len_next;
    len_t     a_good_reg,     a_good_next;
    logic [7:0] low_reg,      low_next;
    offset_t  w_start_reg,    w_start_next;
    len_t     w_pairs_reg,    w_pairs_next;
    len_t     w_good_reg,     w_good_next;
    logic     w_skip_reg,     w_skip_next;
    limit_t   found_reg,      found_next;

    // Result queue
    result_t          q_mem [Q_DEPTH];
    logic [Q_AW-1:0]  q_wr_reg;
    logic [Q_AW-1:0]  q_rd_reg;
    logic [Q_CW-1:0]  q_cnt_reg;

    logic     in_take;
    logic     out_take;
    logic     b_print;
    logic     b_good;
    logic     low_print;
    logic     low_good;
    logic     a_fire;
    logic     w_cand;
    logic     w_fire;
    offset_t  w_rep_start;
    len_t     w_rep_len;
    len_t     w_rep_good;
    offset_t  w_span;
    limit_t   found_mid;
    result_t  a_item;
    result_t  w_item;
    logic [1:0] push_n;

    assign in_take   = in_valid && !in_stall;
    assign out_take  = out_valid && !out_stall;
    assign in_stall  = q_cnt_reg > Q_CW'(Q_DEPTH - 2);
    assign cfg_ready = 1'b1;

    assign b_print   = is_printable(byte_value);
    assign b_good    = is_good(byte_value);
    assign low_print = is_printable(low_reg);
    assign low_good  = is_good(low_reg);

    // Advance the ASCII and UTF-16 run trackers for one byte
    always_comb
    begin
        a_active_next = a_active_reg;
        a_start_next  = a_start_reg;
        a_len_next    = a_len_reg;
        a_good_next   = a_good_reg;
        low_next      = low_reg;
        w_start_next  = w_start_reg;
        w_pairs_next  = w_pairs_reg;
        w_good_next   = w_good_reg;
        w_skip_next   = w_skip_reg;
        a_fire        = 1'b0;
        w_cand        = 1'b0;
        w_rep_start   = w_start_reg;
        w_rep_len     = w_pairs_reg;
        w_rep_good    = w_good_reg;

        // ASCII run
        if (b_print)
        begin
            if (!a_active_reg)
            begin
                a_active_next = 1'b1;
                a_start_next  = pos_reg;
                a_len_next    = len_t'(1);
                a_good_next   = len_t'(b_good);
            end
            else if (a_len_reg < len_t'(RUN_CAP))
            begin
                a_len_next  = a_len_reg + len_t'(1);
                a_good_next = a_good_reg + len_t'(b_good);
            end
        end
        else
        begin
            a_fire        = a_active_reg && run_qualifies(a_len_reg, a_good_reg) &&
                            (found_reg < limit_reg);
            a_active_next = 1'b0;
            a_len_next    = '0;
            a_good_next   = '0;
        end

        // UTF-16LE run, judged on the high byte of each pair
        if (!pos_reg[0])
        begin
            low_next = byte_value;
        end
        else if (w_skip_reg)
        begin
            w_skip_next = 1'b0;
        end
        else if (low_print && (byte_value == 8'h00))
        begin
            if (w_pairs_reg == '0)
            begin
                w_start_next = pos_reg - offset_t'(1);
                w_pairs_next = len_t'(1);
                w_good_next  = len_t'(low_good);
            end
            else
            begin
                w_pairs_next = w_pairs_reg + len_t'(1);
                w_good_next  = w_good_reg + len_t'(low_good);
            end
            if (w_pairs_next >= len_t'(RUN_CAP))
            begin
                w_pairs_next = '0;
                w_good_next  = '0;
                w_skip_next  = 1'b1;
            end
        end
        else
        begin
            w_cand       = w_pairs_reg >= len_t'(MIN_CHARS);
            w_pairs_next = '0;
            w_good_next  = '0;
        end

        // Wide run still open at end of file
        w_span = pos_reg + offset_t'(1) - w_start_next;
        if (last_byte && (w_pairs_next >= len_t'(MIN_CHARS)) && (w_span > offset_t'(8)))
        begin
            w_cand      = 1'b1;
            w_rep_start = w_start_next;
            w_rep_len   = w_pairs_next;
            w_rep_good  = w_good_next;
        end

        found_mid = found_reg + limit_t'(a_fire);
        w_fire    = w_cand && run_qualifies(w_rep_len, w_rep_good) && (found_mid < limit_reg);

        if (last_byte)
        begin
            pos_next      = '0;
            found_next    = '0;
            a_active_next = 1'b0;
            a_start_next  = '0;
            a_len_next    = '0;
            a_good_next   = '0;
            low_next      = '0;
            w_start_next  = '0;
            w_pairs_next  = '0;
            w_good_next   = '0;
            w_skip_next   = 1'b0;
        end
        else
        begin
            pos_next   = pos_reg + offset_t'(1);
            found_next = found_mid + limit_t'(w_fire);
        end
    end

    // Build the result items
    always_comb
    begin
        a_item.kind  = RUN_ASCII;
        a_item.start = a_start_reg;
        a_item.count = a_len_reg[COUNT_W-1:0];
        a_item.eob   = !w_fire;
        w_item.kind  = RUN_WIDE;
        w_item.start = w_rep_start;
        w_item.count = w_rep_len[COUNT_W-1:0];
        w_item.eob   = 1'b1;
        push_n       = {1'b0, a_fire} + {1'b0, w_fire};
    end

    // Hold scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg    <= limit_t'(LIMIT_RESET);
            pos_reg      <= '0;
            a_active_reg <= 1'b0;
            a_start_reg  <= '0;
            a_len_reg    <= '0;
            a_good_reg   <= '0;
            low_reg      <= '0;
            w_start_reg  <= '0;
            w_pairs_reg  <= '0;
            w_good_reg   <= '0;
            w_skip_reg   <= 1'b0;
            found_reg    <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
            if (in_take)
            begin
                pos_reg      <= pos_next;
                a_active_reg <= a_active_next;
                a_start_reg  <= a_start_next;
                a_len_reg    <= a_len_next;
                a_good_reg   <= a_good_next;
                low_reg      <= low_next;
                w_start_reg  <= w_start_next;
                w_pairs_reg  <= w_pairs_next;
                w_good_reg   <= w_good_next;
                w_skip_reg   <= w_skip_next;
                found_reg    <= found_next;
            end
        end
    end

    // Write up to two items into the queue
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            if (a_fire)
            begin
                q_mem[q_wr_reg] <= a_item;
                if (w_fire)
                begin
                    q_mem[q_wr_reg + Q_AW'(1)] <= w_item;
                end
            end
            else if (w_fire)
            begin
                q_mem[q_wr_reg] <= w_item;
            end
        end
    end

    // Advance queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_reg  <= '0;
            q_rd_reg  <= '0;
            q_cnt_reg <= '0;
        end
        else
        begin
            if (in_take)
            begin
                q_wr_reg <= q_wr_reg + Q_AW'(push_n);
            end
            if (out_take)
            begin
                q_rd_reg <= q_rd_reg + Q_AW'(1);
            end
            q_cnt_reg <= q_cnt_reg + (in_take ? Q_CW'(push_n) : Q_CW'(0))
                         - Q_CW'(out_take);
        end
    end

    // Drive the head of the queue
    assign out_valid    = q_cnt_reg != '0;
    assign run_kind     = q_mem[q_rd_reg].kind;
    assign start_offset = q_mem[q_rd_reg].start;
    assign char_count   = q_mem[q_rd_reg].count;
    assign end_of_burst = q_mem[q_rd_reg].eob;

endmodule

`default_nettype wire

// ===== rtl/core/psrf_checker.sv =====
`default_nettype none

module psrf_checker
    import psrf_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_stall,
    input wire logic                 out_valid,
    input wire logic                 out_stall,
    input wire logic                 run_kind,
    input wire logic [OFFSET_W-1:0]  start_offset,
    input wire logic [COUNT_W-1:0]   char_count,
    input wire logic                 end_of_burst
);

    // Hold a stalled result item
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(run_kind) &&
        $stable(start_offset) && $stable(char_count) && $stable(end_of_burst))
        else $error("stalled result item changed");

    // Report only runs within the length window
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (char_count >= COUNT_W'(MIN_CHARS)) &&
        (char_count <= COUNT_W'(MAX_CHARS)))
        else $error("reported run length out of range");

    // Wide runs start on an even offset
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (run_kind == RUN_WIDE) |-> !start_offset[0])
        else $error("wide run starts on odd offset");

    // Never stall input with an empty result queue
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while no results pending");

endmodule

bind printable_string_run_finder psrf_checker u_psrf_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .run_kind     (run_kind),
    .start_offset (start_offset),
    .char_count   (char_count),
    .end_of_burst (end_of_burst)
);

`default_nettype wire

// ===== test/printable_string_run_finder_tb.sv =====
`default_nettype none

module printable_string_run_finder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import psrf_pkg::*;

    localparam int         RESET_CYCLES   = 10;
    localparam int         SETTLE_CYCLES  = 8;
    localparam int         LONG_HOLD      = 400;
    localparam int         WATCHDOG_LIMIT = 5000;
    localparam int         SHOWN_ERRORS   = 10;
    localparam logic [7:0] NUL            = 8'h00;
    localparam logic [7:0] FILLER         = 8'h01;
    localparam logic [7:0] LINE_FEED      = 8'h0A;
    localparam string      GOOD_SET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789._-/:@#";

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                in_valid     = 1'b0;
    logic                in_stall;
    logic [7:0]          byte_value   = 8'h00;
    logic                last_byte    = 1'b0;
    logic                out_valid;
    logic                out_stall    = 1'b0;
    logic                run_kind;
    logic [OFFSET_W-1:0] start_offset;
    logic [COUNT_W-1:0]  char_count;
    logic                end_of_burst;
    logic                cfg_valid    = 1'b0;
    logic                cfg_ready;
    logic [LIMIT_W-1:0]  cfg_data     = '0;

    printable_string_run_finder dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .byte_value   (byte_value),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .run_kind     (run_kind),
        .start_offset (start_offset),
        .char_count   (char_count),
        .end_of_burst (end_of_burst),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Scanner state mirrored from the block
    bit [LIMIT_W-1:0]  limit_q   = LIMIT_W'(LIMIT_RESET);
    bit [LIMIT_W-1:0]  reported;
    bit [31:0]         pos;
    bit                asc_on;
    bit [31:0]         asc_from;
    int                asc_len;
    int                asc_good;
    bit [7:0]          low_byte;
    bit [31:0]         wide_from;
    int                wide_len;
    int                wide_good;
    bit                skip_next;
    result_t           step_runs[$];
    result_t           pending_runs[$];

    int mismatches  = 0;
    int burst_left  = 0;
    int hold_req    = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int stall_pct   = 0;
    int mode_left   = 0;
    int quiet_cycles = 0;

    function automatic bit printable(bit [7:0] b);
        return (b >= 8'd32) && (b <= 8'd126);
    endfunction

    function automatic bit good_char(bit [7:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || (b >= "0" && b <= "9") ||
               b == "." || b == "_" || b == "-" || b == "/" || b == ":" || b == "@" ||
               b == "#";
    endfunction

    task automatic clear_scan();
        reported  = '0;
        pos       = '0;
        asc_on    = 1'b0;
        asc_from  = '0;
        asc_len   = 0;
        asc_good  = 0;
        low_byte  = '0;
        wide_from = '0;
        wide_len  = 0;
        wide_good = 0;
        skip_next = 1'b0;
    endtask

    // Queue a run if it passes the length window, ratio and limit
    task automatic offer_run(run_kind_t kind, bit [31:0] from, int len, int good);
        result_t r;
        if (reported >= limit_q)
            return;
        if (len < MIN_CHARS || len > MAX_CHARS)
            return;
        if (good * 5 <= len * 4)
            return;
        r.kind  = kind;
        r.start = from;
        r.count = COUNT_W'(len);
        r.eob   = 1'b0;
        step_runs.push_back(r);
        reported = reported + 1'b1;
    endtask

    // Advance the scanner by one byte and store the runs it closes
    task automatic find_runs(bit [7:0] b, bit is_last);
        bit [31:0] span;
        result_t   r;
        step_runs.delete();

        // ASCII runs
        if (printable(b))
        begin
            if (!asc_on)
            begin
                asc_on   = 1'b1;
                asc_from = pos;
                asc_len  = 1;
                asc_good = good_char(b);
            end
            else if (asc_len < RUN_CAP)
            begin
                asc_len++;
                if (good_char(b))
                    asc_good++;
            end
        end
        else
        begin
            if (asc_on)
                offer_run(RUN_ASCII, asc_from, asc_len, asc_good);
            asc_on   = 1'b0;
            asc_len  = 0;
            asc_good = 0;
        end

        // UTF-16LE runs, judged on the high byte
        if (!pos[0])
            low_byte = b;
        else if (skip_next)
            skip_next = 1'b0;
        else if (printable(low_byte) && b == NUL)
        begin
            if (wide_len == 0)
            begin
                wide_from = pos - 32'd1;
                wide_len  = 1;
                wide_good = good_char(low_byte);
            end
            else
            begin
                wide_len++;
                if (good_char(low_byte))
                    wide_good++;
            end
            if (wide_len >= RUN_CAP)
            begin
                wide_len  = 0;
                wide_good = 0;
                skip_next = 1'b1;
            end
        end
        else
        begin
            if (wide_len >= MIN_CHARS)
                offer_run(RUN_WIDE, wide_from, wide_len, wide_good);
            wide_len  = 0;
            wide_good = 0;
        end

        // Open wide run at end of file
        span = pos + 32'd1 - wide_from;
        if (is_last && wide_len >= MIN_CHARS && span > 32'd8)
            offer_run(RUN_WIDE, wide_from, wide_len, wide_good);

        for (int i = 0; i < step_runs.size(); i++)
        begin
            r     = step_runs[i];
            r.eob = (i == step_runs.size() - 1);
            pending_runs.push_back(r);
        end

        if (is_last)
            clear_scan();
        else
            pos++;
    endtask

    // Offer one item in bursts with random gaps, hold it until accepted
    task automatic send_byte(bit [7:0] b, bit is_last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 16);
            gap = $urandom_range(0, 5);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        byte_value <= b;
        last_byte  <= is_last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        find_runs(b, is_last);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    task automatic send_repeat(bit [7:0] b, int n);
        for (int i = 0; i < n; i++)
            send_byte(b, 1'b0);
    endtask

    // Even-aligned pairs of character and zero
    task automatic send_wide(string s);
        if (pos[0])
            send_byte(FILLER, 1'b0);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i], 1'b0);
            send_byte(NUL, 1'b0);
        end
    endtask

    task automatic send_wide_repeat(bit [7:0] ch, int n);
        if (pos[0])
            send_byte(FILLER, 1'b0);
        for (int i = 0; i < n; i++)
        begin
            send_byte(ch, 1'b0);
            send_byte(NUL, 1'b0);
        end
    endtask

    task automatic break_pair();
        send_byte(FILLER, 1'b0);
        send_byte(FILLER, 1'b0);
    endtask

    // Drop valid, wait for every pending run, then let the block go quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_runs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(bit [LIMIT_W-1:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        limit_q = v;
    endtask

    function automatic bit [7:0] text_char();
        if ($urandom_range(0, 9) < 8)
            return GOOD_SET[$urandom_range(0, GOOD_SET.len() - 1)];
        return 8'($urandom_range(32, 126));
    endfunction

    // Mix of text runs, wide runs, noise and breaks, ended at a random byte
    task automatic send_random_file(int nbytes);
        int start_pos;
        int n;
        start_pos = pos;
        while (pos - start_pos < nbytes)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60)
                                                    : $urandom_range(1, 12);
                    for (int i = 0; i < n; i++)
                        send_byte(text_char(), 1'b0);
                end
                4, 5, 6:
                begin
                    if (pos[0])
                        send_byte(8'($urandom_range(0, 255)), 1'b0);
                    n = $urandom_range(1, 10);
                    for (int i = 0; i < n; i++)
                    begin
                        send_byte(text_char(), 1'b0);
                        if ($urandom_range(0, 5) == 0)
                            send_byte(8'($urandom_range(0, 255)), 1'b0);
                        else
                            send_byte(NUL, 1'b0);
                    end
                end
                7, 8:
                begin
                    n = $urandom_range(1, 6);
                    for (int i = 0; i < n; i++)
                        send_byte(8'($urandom_range(0, 255)), 1'b0);
                end
                default:
                    send_byte(8'($urandom_range(0, 31)), 1'b0);
            endcase
        end
        send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // One text run and one wide run per repetition
    task automatic send_tagged_file(int reps);
        for (int i = 0; i < reps; i++)
        begin
            send_text("id:42/x");
            send_byte(LINE_FEED, 1'b0);
            send_wide("Name");
            break_pair();
        end
        send_byte(NUL, 1'b1);
    endtask

    // ASCII length window, ratio boundary, saturation and end of file
    task automatic test_ascii_edges();
        send_text("abc");
        send_byte(LINE_FEED, 1'b0);
        send_text("wxyz");
        send_byte(NUL, 1'b0);
        send_text("abcd!");
        send_byte(8'h7F, 1'b0);
        send_text("abcde");
        send_byte(8'hFF, 1'b0);
        send_text(" ABCDEFGHIJKLMNOPQRS~");
        send_byte(8'h1F, 1'b0);
        send_repeat("a", MAX_CHARS);
        send_byte(8'h80, 1'b0);
        send_repeat("b", MAX_CHARS + 1);
        send_byte(8'hFF, 1'b0);
        send_repeat("c", RUN_CAP + 7);
        send_byte(8'h0D, 1'b0);
        send_text("tai");
        send_byte("l", 1'b1);
        send_text("qrst");
        send_byte(NUL, 1'b1);
    endtask

    // Wide runs: length window, misalignment, breaks, cap and end of file
    task automatic test_wide_runs();
        send_wide("abc");
        break_pair();
        send_wide("Wide");
        break_pair();
        if (!pos[0])
            send_byte(FILLER, 1'b0);
        send_wide_repeat("O", 5);
        send_byte(NUL, 1'b0);
        send_wide("Hi/x");
        send_byte("a", 1'b0);
        send_byte(FILLER, 1'b0);
        send_wide("Tag:");
        send_byte("q", 1'b0);
        send_byte(8'h80, 1'b0);
        send_wide("ab  cd");
        break_pair();
        send_wide_repeat("x", MAX_CHARS);
        break_pair();
        send_wide_repeat("y", MAX_CHARS + 1);
        break_pair();
        send_wide_repeat("A", RUN_CAP);
        send_wide("B");
        send_wide("CDEFG");
        break_pair();
        send_byte(LINE_FEED, 1'b1);

        // Four pairs ending the file: exactly eight bytes, dropped
        send_wide("abc");
        send_byte("d", 1'b0);
        send_byte(NUL, 1'b1);
        // Five pairs ending the file
        send_wide("abcd");
        send_byte("e", 1'b0);
        send_byte(NUL, 1'b1);
        // Lone low byte after four pairs
        send_wide("wxyz");
        send_byte("e", 1'b1);
        // Run broken by the final high byte
        send_wide("path");
        send_byte("q", 1'b0);
        send_byte(8'h55, 1'b1);
    endtask

    // Report limit at its extremes; count restarts with each file
    task automatic test_found_limit();
        write_limit('0);
        send_tagged_file(2);
        write_limit(LIMIT_W'(2));
        send_tagged_file(2);
        send_tagged_file(2);
        write_limit('1);
        send_tagged_file(2);
        write_limit(LIMIT_W'(1));
        send_tagged_file(1);
        write_limit(LIMIT_W'($urandom_range(3, 6)));
        send_tagged_file(3);
    endtask

    // Long receiver hold while text keeps coming, then drain
    task automatic test_backpressure();
        write_limit(LIMIT_W'(LIMIT_RESET));
        hold_req <= hold_req + 1;
        for (int i = 0; i < 40; i++)
        begin
            send_text("abcd");
            send_byte(LINE_FEED, 1'b0);
        end
        send_byte(NUL, 1'b1);
        settle();
    endtask

    task automatic test_random_files();
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:       write_limit(LIMIT_W'(LIMIT_RESET));
                1:       write_limit(LIMIT_W'($urandom_range(1, 4)));
                2:       write_limit('1);
                3:       write_limit(LIMIT_W'($urandom_range(0, (1 << LIMIT_W) - 1)));
                default: write_limit(LIMIT_W'($urandom_range(8, 40)));
            endcase
            for (int f = 0; f < 3; f++)
                send_random_file($urandom_range(20, 45));
        end
    endtask

    // Receiver stall pattern, plus a long hold on request
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
        end
        if (mode_left == 0)
        begin
            mode_left = $urandom_range(32, 256);
            case ($urandom_range(0, 3))
                0:       stall_pct = 0;
                1:       stall_pct = 25;
                2:       stall_pct = 50;
                default: stall_pct = 85;
            endcase
        end
        mode_left--;
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    task automatic note_mismatch(string what, result_t want);
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
            $display("%s: expected kind=%0d start=%0d count=%0d eob=%0d, got kind=%0d start=%0d count=%0d eob=%0d",
                     what, want.kind, want.start, want.count, want.eob,
                     run_kind, start_offset, char_count, end_of_burst);
    endtask

    // Compare each accepted result with the oldest pending run
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_runs.size() == 0)
            begin
                want = '0;
                note_mismatch("unexpected result", want);
            end
            else
            begin
                want = pending_runs.pop_front();
                if (run_kind !== want.kind)
                    note_mismatch("run_kind", want);
                if (start_offset !== want.start)
                    note_mismatch("start_offset", want);
                if (char_count !== want.count)
                    note_mismatch("char_count", want);
                if (end_of_burst !== want.eob)
                    note_mismatch("end_of_burst", want);
            end
        end
    end

    // End the run if nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        clear_scan();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ascii_edges();
        test_wide_runs();
        test_found_limit();
        test_backpressure();
        test_random_files();

        settle();
        mismatches += pending_runs.size();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
